// ===== hw/rtl/tpk_pkg.sv =====
// Package: shared types, constants and coefficient function for the tangent-point kernel.
`default_nettype none
package tpk_pkg;

  localparam int COORD_BITS_DEF      = 32;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int FIELD_W  = 32;
  localparam int LOG_FRAC = 20;
  localparam int T_FRAC   = 33;
  localparam int LOG_W    = 30;
  localparam int T_W      = 50;
  localparam int IP_W     = T_W - T_FRAC;
  localparam int LOG_LAT  = LOG_FRAC + 2;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_EXP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN_EXP = 8'd1;

  localparam logic [15:0] NUM_EXP_RESET = 16'd24576;
  localparam logic [15:0] DEN_EXP_RESET = 16'd49152;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_ZERO_DISP = 2'd2;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
  } tpk_in_t;

  typedef struct packed {
    logic [63:0] kernel_value;
    logic [1:0]  status;
  } tpk_out_t;

  typedef struct packed {
    logic zero_disp;
    logic zero_dot;
  } tpk_flags_t;

  typedef logic [LOG_FRAC-1:0][31:0] coef_t;

  // c0 = 1.0 (Q1.32), ck = isqrt(c(k-1) << 31): Q1.31 values of 2^(2^-k)
  function automatic coef_t exp_coefs();
    coef_t       tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'h1_0000_0000;
    for (int k = 0; k < LOG_FRAC; k++) begin
      v = c << 31;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
      tab[k] = c[31:0];
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tpk_front.sv =====
// Front end: displacement, products, dot-product magnitude and squared distance.
`default_nettype none
module tpk_front #(
  parameter int COORD_BITS = 32,
  parameter int XW = 2 * COORD_BITS + 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_vld,
  input  wire tpk_pkg::tpk_in_t in_data,
  output logic                  out_vld,
  output logic [XW-1:0]         dot_mag,
  output logic [XW-1:0]         dist_sq,
  output tpk_pkg::tpk_flags_t   flags
);
  import tpk_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * CB + 2;

  logic [CB-1:0]   px, py, pz, qx, qy, qz, nx, ny, nz;
  logic signed [DW-1:0] d_nxt [3];

  logic signed [DW-1:0] d_r [3];
  logic signed [CB-1:0] n_r [3];
  logic                 v1_r, zd1_r;

  logic signed [PW-1:0] nd_r [3];
  logic signed [PW-1:0] dd_r [3];
  logic                 v2_r, zd2_r;

  logic signed [XW-1:0] dot_sum;
  logic [XW-1:0]        dot_abs, sq_sum;
  logic [XW-1:0]        dot_r, sq_r;
  logic                 v3_r;
  tpk_flags_t           fl_r;

  assign px = CB'($unsigned(in_data.first_x));
  assign py = CB'($unsigned(in_data.first_y));
  assign pz = CB'($unsigned(in_data.first_z));
  assign qx = CB'($unsigned(in_data.second_x));
  assign qy = CB'($unsigned(in_data.second_y));
  assign qz = CB'($unsigned(in_data.second_z));
  assign nx = CB'($unsigned(in_data.normal_x));
  assign ny = CB'($unsigned(in_data.normal_y));
  assign nz = CB'($unsigned(in_data.normal_z));

  always_comb begin
    d_nxt[0] = $signed({px[CB-1], px}) - $signed({qx[CB-1], qx});
    d_nxt[1] = $signed({py[CB-1], py}) - $signed({qy[CB-1], qy});
    d_nxt[2] = $signed({pz[CB-1], pz}) - $signed({qz[CB-1], qz});
  end

  always_comb begin
    dot_sum = XW'(nd_r[0]) + XW'(nd_r[1]) + XW'(nd_r[2]);
    dot_abs = dot_sum[XW-1] ? XW'(-dot_sum) : XW'(dot_sum);
    sq_sum  = XW'($unsigned(dd_r[0])) + XW'($unsigned(dd_r[1])) + XW'($unsigned(dd_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]  <= d_nxt[i];
        nd_r[i] <= PW'(n_r[i] * d_r[i]);
        dd_r[i] <= PW'(d_r[i] * d_r[i]);
      end
      n_r[0] <= $signed(nx);
      n_r[1] <= $signed(ny);
      n_r[2] <= $signed(nz);
      zd1_r <= (d_nxt[0] == '0) && (d_nxt[1] == '0) && (d_nxt[2] == '0);
      zd2_r <= zd1_r;
      dot_r <= dot_abs;
      sq_r  <= sq_sum;
      fl_r.zero_disp <= zd2_r;
      fl_r.zero_dot  <= (dot_sum == '0);
    end
  end

  assign out_vld = v3_r;
  assign dot_mag = dot_r;
  assign dist_sq = sq_r;
  assign flags   = fl_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tpk_log2.sv =====
// Pipelined fixed-point log2: leading-one search, normalise, one squaring per stage.
`default_nettype none
module tpk_log2 #(
  parameter int XW = 68,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [XW-1:0]                x,
  output logic signed [tpk_pkg::LOG_W-1:0]  log_val
);
  import tpk_pkg::*;

  localparam int EW = $clog2(XW);

  logic [EW-1:0] lead;
  logic [XW-1:0] x1_r;
  logic [EW-1:0] e1_r;
  logic [XW-1:0] sh_val;
  logic [31:0]   mant;

  logic [31:0]         m_r [LOG_FRAC+1];
  logic [EW-1:0]       e_r [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] f_r [LOG_FRAC+1];

  logic [63:0] sq [LOG_FRAC];
  logic signed [LOG_W-1:0] ev;

  always_comb begin
    lead = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) lead = EW'(i);
    end
  end

  always_comb begin
    if (e1_r >= EW'(31)) begin
      sh_val = x1_r >> (e1_r - EW'(31));
    end else begin
      sh_val = x1_r << (EW'(31) - e1_r);
    end
    mant = sh_val[31:0];
  end

  always_comb begin
    for (int k = 0; k < LOG_FRAC; k++) begin
      sq[k] = 64'(m_r[k]) * 64'(m_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x;
      e1_r   <= lead;
      m_r[0] <= mant;
      e_r[0] <= e1_r;
      f_r[0] <= '0;
      for (int k = 0; k < LOG_FRAC; k++) begin
        e_r[k+1] <= e_r[k];
        f_r[k+1] <= {f_r[k][LOG_FRAC-2:0], sq[k][63]};
        m_r[k+1] <= sq[k][63] ? sq[k][63:32] : sq[k][62:31];
      end
    end
  end

  assign ev      = LOG_W'(e_r[LOG_FRAC]) - LOG_W'(2 * FRAC_BITS);
  assign log_val = {ev[LOG_W-LOG_FRAC-1:0], f_r[LOG_FRAC]};

endmodule
`default_nettype wire

// ===== hw/rtl/tpk_exp2.sv =====
// Exponent combine, pipelined exp2 over fraction bits, final shift and special cases.
`default_nettype none
module tpk_exp2 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic signed [tpk_pkg::LOG_W-1:0] log_d,
  input  wire logic signed [tpk_pkg::LOG_W-1:0] log_s,
  input  wire tpk_pkg::tpk_flags_t         flags,
  input  wire logic [15:0]                 alpha,
  input  wire logic [15:0]                 beta,
  output logic                             out_vld,
  output tpk_pkg::tpk_out_t                out_data
);
  import tpk_pkg::*;

  localparam int PAW = LOG_W + 17;
  localparam coef_t COEF = exp_coefs();
  localparam int NS = LOG_FRAC + 1;

  logic signed [PAW-1:0] pa_r, pb_r;
  logic                  v1_r;
  tpk_flags_t            fl1_r;

  logic signed [T_W-1:0] ev;

  logic [31:0]          m_r   [NS];
  logic [LOG_FRAC-1:0]  g_r   [NS];
  logic signed [IP_W-1:0] ip_r [NS];
  logic                 ovf_r [NS];
  tpk_flags_t           fl_r  [NS];
  logic                 v_r   [NS];
  logic [63:0]          prod  [LOG_FRAC];

  logic signed [IP_W-1:0] ipf;
  logic [IP_W-1:0]        rsh;
  logic [63:0]            shifted;
  tpk_out_t               res_nxt, res_r;
  logic                   vo_r;

  always_comb begin
    ev = (T_W'(pa_r) <<< 1) - T_W'(pb_r) + (T_W'(32) <<< T_FRAC);
    for (int k = 0; k < LOG_FRAC; k++) begin
      prod[k] = 64'(m_r[k]) * 64'(COEF[k]);
    end
  end

  always_comb begin
    ipf = ip_r[LOG_FRAC];
    rsh = IP_W'(IP_W'(31) - ipf);
    if (ipf >= IP_W'(31)) begin
      shifted = {32'd0, m_r[LOG_FRAC]} << (6'(ipf - IP_W'(31)));
    end else if (rsh >= IP_W'(64)) begin
      shifted = '0;
    end else begin
      shifted = {32'd0, m_r[LOG_FRAC]} >> rsh[5:0];
    end
    res_nxt.status = ST_OK;
    if (fl_r[LOG_FRAC].zero_disp) begin
      res_nxt.kernel_value = '1;
      res_nxt.status       = ST_ZERO_DISP;
    end else if (fl_r[LOG_FRAC].zero_dot) begin
      res_nxt.kernel_value = (alpha == '0) ? 64'h1_0000_0000 : '0;
    end else if (ovf_r[LOG_FRAC]) begin
      res_nxt.kernel_value = '1;
      res_nxt.status       = ST_OVERFLOW;
    end else begin
      res_nxt.kernel_value = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k < NS; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v_r[0] <= v1_r;
      for (int k = 0; k < LOG_FRAC; k++) v_r[k+1] <= v_r[k];
      vo_r <= v_r[LOG_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= PAW'($signed({1'b0, alpha}) * log_d);
      pb_r  <= PAW'($signed({1'b0, beta}) * log_s);
      fl1_r <= flags;
      m_r[0]   <= 32'h8000_0000;
      g_r[0]   <= ev[T_FRAC-1 -: LOG_FRAC];
      ip_r[0]  <= ev[T_W-1:T_FRAC];
      ovf_r[0] <= $signed(ev[T_W-1:T_FRAC]) >= $signed(IP_W'(64));
      fl_r[0]  <= fl1_r;
      for (int k = 0; k < LOG_FRAC; k++) begin
        m_r[k+1]   <= g_r[k][LOG_FRAC-1-k] ? prod[k][62:31] : m_r[k];
        g_r[k+1]   <= g_r[k];
        ip_r[k+1]  <= ip_r[k];
        ovf_r[k+1] <= ovf_r[k];
        fl_r[k+1]  <= fl_r[k];
      end
      res_r <= res_nxt;
    end
  end

  assign out_vld  = vo_r;
  assign out_data = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tangent_point_kernel_unit.sv =====
// Top level: tangent-point kernel pipeline with configuration registers.
//
// Usage:
//   Input beats (two points and a normal, Q16.16) enter on in_valid/in_data,
//   held off by in_stall. Results (kernel_value Q32.32, status) leave on
//   out_valid/out_data; the receiver holds them with out_stall.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//   is alpha, index 1 is beta (Q4.12); other indexes are ignored. cfg_ready
//   is always high; write only while no item is in flight.
// Timing:
//   One item per cycle while not stalled. Stages: 3 front-end, 22 log2
//   (leading-one search, normalise, one squaring per fraction bit),
//   2 exponent, 20 exp2 multiply and the output register.
// Reset:
//   rst_n clears all valid bits and loads alpha = 6.0, beta = 12.0.
// Stall:
//   While a result sits in the output register with out_stall high, the
//   whole pipeline freezes and in_stall is raised; nothing is dropped.
`default_nettype none
module tangent_point_kernel_unit #(
  parameter int COORD_BITS      = tpk_pkg::COORD_BITS_DEF,
  parameter int COORD_FRAC_BITS = tpk_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tpk_pkg::tpk_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tpk_pkg::tpk_out_t                      out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tpk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                       cfg_data
);
  import tpk_pkg::*;

  localparam int XW = 2 * COORD_BITS + 4;

  logic        en;
  logic [15:0] alpha_r, beta_r;

  logic          fr_vld;
  logic [XW-1:0] dot_mag, dist_sq;
  tpk_flags_t    fr_flags;

  logic signed [LOG_W-1:0] log_d, log_s;

  logic       dv_r  [LOG_LAT];
  tpk_flags_t dfl_r [LOG_LAT];

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= NUM_EXP_RESET;
      beta_r  <= DEN_EXP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_NUM_EXP) alpha_r <= cfg_data;
      if (cfg_index == CFG_DEN_EXP) beta_r  <= cfg_data;
    end
  end

  tpk_front #(.COORD_BITS(COORD_BITS), .XW(XW)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_data (in_data),
    .out_vld (fr_vld),
    .dot_mag (dot_mag),
    .dist_sq (dist_sq),
    .flags   (fr_flags)
  );

  tpk_log2 #(.XW(XW), .FRAC_BITS(COORD_FRAC_BITS)) u_log_dot (
    .clk     (clk),
    .en      (en),
    .x       (dot_mag),
    .log_val (log_d)
  );

  tpk_log2 #(.XW(XW), .FRAC_BITS(COORD_FRAC_BITS)) u_log_dist (
    .clk     (clk),
    .en      (en),
    .x       (dist_sq),
    .log_val (log_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LOG_LAT; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= fr_vld;
      for (int k = 1; k < LOG_LAT; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dfl_r[0] <= fr_flags;
      for (int k = 1; k < LOG_LAT; k++) dfl_r[k] <= dfl_r[k-1];
    end
  end

  tpk_exp2 u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dv_r[LOG_LAT-1]),
    .log_d    (log_d),
    .log_s    (log_s),
    .flags    (dfl_r[LOG_LAT-1]),
    .alpha    (alpha_r),
    .beta     (beta_r),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
